### sv/nvnf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the nearest value neighbour filter.
// No dependencies; the front, back and top-level files import this package.
package nvnf_pkg;

  localparam int PIXEL_W        = 8;
  localparam int FRAME_WIDTH_W  = 12;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 1;

  localparam int MAX_WIDTH_DEFAULT  = 2048;
  localparam int MAX_HEIGHT_DEFAULT = 4096;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = FRAME_WIDTH_W'(640);
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = FRAME_HEIGHT_W'(480);

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam int COL_QUEUE_DEPTH = 4;
  localparam int COL_COUNT_W     = $clog2(COL_QUEUE_DEPTH + 1);
  localparam int OUT_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [PIXEL_W-1:0] top;
    logic [PIXEL_W-1:0] mid;
    logic [PIXEL_W-1:0] sample;
    logic               mid_ok;
  } column_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               end_of_row;
    logic               end_of_frame;
  } result_t;

endpackage

### sv/nvnf_fifo.sv
`timescale 1ns / 1ps
// Small register queue with occupancy count.
// Depends on nothing; used between front and back and on the result side.
module nvnf_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == NW'(0));
  assign full    = (count == NW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/nvnf_front.sv
`timescale 1ns / 1ps
// Front end: accepts pixel and drain transactions, keeps the two line stores
// and builds one window column per transaction. Depends on nvnf_pkg.
module nvnf_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
  input  logic                              push,
  input  logic                              func,
  input  logic [nvnf_pkg::PIXEL_W-1:0]      pixel_in,
  input  logic [nvnf_pkg::COL_COUNT_W-1:0]  queue_count,
  output logic                              full,
  output logic                              col_push,
  output nvnf_pkg::column_t                 col_data
);
  import nvnf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [PIXEL_W:0]   middle_mem [MAX_WIDTH];
  logic [PIXEL_W-1:0] upper_mem  [MAX_WIDTH];

  logic [CW-1:0]      in_column;
  logic               first_row_done;
  logic               accept;
  logic               is_pixel;
  logic [PIXEL_W-1:0] sample;

  logic               s1_valid;
  logic [CW-1:0]      s1_addr;
  logic [PIXEL_W-1:0] s1_sample;
  logic               s1_filled;
  logic               byp_hit;
  logic [PIXEL_W-1:0] byp_data;
  logic [PIXEL_W:0]   mid_rd;
  logic [PIXEL_W-1:0] up_rd;

  assign full     = (32'(queue_count) + 32'(s1_valid)) >= COL_QUEUE_DEPTH;
  assign accept   = push && !full;
  assign is_pixel = (func == FUNC_PIXEL);
  assign sample   = is_pixel ? pixel_in : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      middle_mem[in_column] <= {is_pixel, sample};
    end
    mid_rd <= middle_mem[in_column];
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      upper_mem[s1_addr] <= mid_rd[PIXEL_W-1:0];
    end
    up_rd <= upper_mem[in_column];
  end

  always_ff @(posedge clk) begin
    s1_addr   <= in_column;
    s1_sample <= sample;
    s1_filled <= first_row_done;
    byp_hit   <= s1_valid && (s1_addr == in_column);
    byp_data  <= mid_rd[PIXEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      in_column      <= '0;
      first_row_done <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (restart) begin
        in_column      <= '0;
        first_row_done <= 1'b0;
      end else if (accept) begin
        if (32'(in_column) + 32'd1 >= 32'(width)) begin
          in_column      <= '0;
          first_row_done <= 1'b1;
        end else begin
          in_column <= in_column + CW'(1);
        end
      end
    end
  end

  assign col_push        = s1_valid;
  assign col_data.top    = byp_hit ? byp_data : up_rd;
  assign col_data.mid    = mid_rd[PIXEL_W-1:0];
  assign col_data.sample = s1_sample;
  assign col_data.mid_ok = s1_filled && mid_rd[PIXEL_W];

endmodule

### sv/nvnf_back.sv
`timescale 1ns / 1ps
// Back end: shifts columns into the 3x3 window, tracks the output raster
// position and picks the nearest neighbour for interior pixels. Depends on nvnf_pkg.
module nvnf_back #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    height,
  input  logic                               col_avail,
  input  nvnf_pkg::column_t                  col_data,
  output logic                               col_pop,
  input  logic                               res_full,
  output logic                               res_push,
  output nvnf_pkg::result_t                  res_data
);
  import nvnf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  function automatic logic [PIXEL_W-1:0] nearest(
    input logic [PIXEL_W-1:0]        centre,
    input logic [7:0][PIXEL_W-1:0]   cand
  );
    logic [7:0][PIXEL_W-1:0] d;
    logic [3:0][PIXEL_W-1:0] d1;
    logic [3:0][PIXEL_W-1:0] v1;
    logic [1:0][PIXEL_W-1:0] d2;
    logic [1:0][PIXEL_W-1:0] v2;
    for (int k = 0; k < 8; k++) begin
      d[k] = (cand[k] > centre) ? cand[k] - centre : centre - cand[k];
    end
    for (int k = 0; k < 4; k++) begin
      if (d[2*k+1] < d[2*k]) begin
        d1[k] = d[2*k+1];
        v1[k] = cand[2*k+1];
      end else begin
        d1[k] = d[2*k];
        v1[k] = cand[2*k];
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (d1[2*k+1] < d1[2*k]) begin
        d2[k] = d1[2*k+1];
        v2[k] = v1[2*k+1];
      end else begin
        d2[k] = d1[2*k];
        v2[k] = v1[2*k];
      end
    end
    return (d2[1] < d2[0]) ? v2[1] : v2[0];
  endfunction

  logic [2:0][2:0][PIXEL_W-1:0] win;
  logic [2:0]                   col_valid;
  logic [CW-1:0]                out_column;
  logic [RW-1:0]                out_row;
  logic                         emit;
  logic                         interior;
  logic                         eor;
  logic                         eof;
  logic                         advance;
  logic                         last_col;
  logic                         last_row;
  logic [7:0][PIXEL_W-1:0]      cand;

  assign advance  = col_avail && (!emit || !res_full);
  assign col_pop  = advance;
  assign res_push = emit && !res_full;
  assign last_col = (32'(out_column) + 32'd1 == 32'(width));
  assign last_row = (32'(out_row) + 32'd1 == 32'(height));

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= col_data.top;
      win[1][2] <= col_data.mid;
      win[2][2] <= col_data.sample;
      interior  <= (out_column != '0) && (32'(out_column) + 32'd2 <= 32'(width)) &&
                   (out_row != '0) && (32'(out_row) + 32'd2 <= 32'(height));
      eor       <= last_col;
      eof       <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_valid  <= '0;
      out_column <= '0;
      out_row    <= '0;
      emit       <= 1'b0;
    end else if (advance) begin
      col_valid <= {col_data.mid_ok, col_valid[2], col_valid[1]};
      emit      <= col_valid[2];
      if (col_valid[2]) begin
        if (last_col) begin
          out_column <= '0;
          out_row    <= last_row ? '0 : out_row + RW'(1);
        end else begin
          out_column <= out_column + CW'(1);
        end
      end
    end else if (res_push) begin
      emit <= 1'b0;
    end
  end

  assign cand = {win[2][2], win[2][1], win[2][0], win[1][2],
                 win[1][0], win[0][2], win[0][1], win[0][0]};

  assign res_data.pixel        = interior ? nearest(win[1][1], cand) : win[1][1];
  assign res_data.end_of_row   = eor;
  assign res_data.end_of_frame = eof;

endmodule

### sv/nearest_value_neighbour_filter.sv
`timescale 1ns / 1ps
// Nearest value neighbour filter, top level. Uses nvnf_pkg, nvnf_fifo,
// nvnf_front and nvnf_back.
// Throughput: one transaction per cycle on both sides while full and empty stay
// low; output is the pixel accepted width+1 transactions earlier. After the
// transaction that completes its window, a result passes the front's line-store
// read register, the column queue, the window register and the result queue.
// Reset: synchronous; counters and queues clear, registers load 640 x 480.
// The line stores need no clearing pass: a first-row flag marks them filled.
module nearest_value_neighbour_filter #(
  parameter int MAX_WIDTH  = nvnf_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = nvnf_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             func,
  input  logic [nvnf_pkg::PIXEL_W-1:0]     pixel_in,
  output logic                             empty,
  input  logic                             pop,
  output logic [nvnf_pkg::PIXEL_W-1:0]     pixel_out,
  output logic                             end_of_row,
  output logic                             end_of_frame,
  input  logic                             cfg_we,
  input  logic [nvnf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nvnf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nvnf_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic [WW-1:0]             width;
  logic [HW-1:0]             height;

  logic                      col_push;
  column_t                   col_in;
  column_t                   col_out;
  logic [COL_COUNT_W-1:0]    col_count;
  logic                      col_empty;
  logic                      col_full;
  logic                      col_pop;

  logic                      res_push;
  logic                      res_full;
  result_t                   res_in;
  result_t                   res_out;
  logic [$clog2(OUT_QUEUE_DEPTH+1)-1:0] res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      width = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = WW'(frame_width);
    end
    if (frame_height == '0) begin
      height = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height = HW'(MAX_HEIGHT);
    end else begin
      height = HW'(frame_height);
    end
  end

  nvnf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_we),
    .width       (width),
    .push        (push),
    .func        (func),
    .pixel_in    (pixel_in),
    .queue_count (col_count),
    .full        (full),
    .col_push    (col_push),
    .col_data    (col_in)
  );

  nvnf_fifo #(
    .DEPTH (COL_QUEUE_DEPTH),
    .WIDTH ($bits(column_t))
  ) u_col_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (col_push),
    .din   (col_in),
    .pop   (col_pop),
    .dout  (col_out),
    .empty (col_empty),
    .full  (col_full),
    .count (col_count)
  );

  nvnf_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_we),
    .width     (width),
    .height    (height),
    .col_avail (!col_empty && !col_full || !col_empty),
    .col_data  (col_out),
    .col_pop   (col_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  nvnf_fifo #(
    .DEPTH (OUT_QUEUE_DEPTH),
    .WIDTH ($bits(result_t))
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty),
    .full  (res_full),
    .count (res_count)
  );

  assign pixel_out    = res_out.pixel;
  assign end_of_row   = res_out.end_of_row;
  assign end_of_frame = res_out.end_of_frame && (res_count != '0);

endmodule
